FILE: design/ipsb_pkg.sv
// Package for the address score and block table.
// Holds request codes, status codes and the cell command struct; no dependencies.
package ipsb_pkg;

    localparam logic FUNC_ADD   = 1'b0;
    localparam logic FUNC_CHECK = 1'b1;

    typedef enum logic [2:0] {
        ST_HIT       = 3'd0,
        ST_NEW       = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_DROPPED   = 3'd3,
        ST_IGNORED   = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_OUT
    } state_t;

    // Broadcast from the controller to every cell during the update cycle.
    typedef struct packed {
        logic        write;      // the targeted cell takes new contents
        logic        promote;    // apply the LRU aging
        logic [31:0] address;
        logic [31:0] score;
        logic [31:0] wstart;
        logic [31:0] expiry;
    } cell_cmd_t;

endpackage

FILE: design/ipsb_cell.sv
// One table cell: address, score, window start, expiry, valid bit and LRU rank.
// Depends on ipsb_pkg. Matches the request address and passes the free chain to its neighbor.
module ipsb_cell #(
    parameter int RW = 6
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [31:0]         match_addr,
    input  logic                sel,
    input  logic [RW:0]         old_rank,
    input  ipsb_pkg::cell_cmd_t cmd,
    input  logic                free_in,
    output logic                free_out,
    output logic                hit,
    output logic                valid,
    output logic [RW-1:0]       rank,
    output logic [31:0]         score,
    output logic [31:0]         wstart,
    output logic [31:0]         expiry
);
    import ipsb_pkg::*;

    logic          valid_reg;
    logic [RW-1:0] rank_reg;
    logic [31:0]   addr_reg;
    logic [31:0]   score_reg;
    logic [31:0]   wstart_reg;
    logic [31:0]   expiry_reg;

    assign hit      = valid_reg && (addr_reg == match_addr);
    assign free_out = free_in || !valid_reg;
    assign valid    = valid_reg;
    assign rank     = rank_reg;
    assign score    = score_reg;
    assign wstart   = wstart_reg;
    assign expiry   = expiry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rank_reg  <= '0;
        end
        else if (cmd.promote)
        begin
            if (sel)
            begin
                valid_reg <= 1'b1;
                rank_reg  <= '0;
            end
            else if (valid_reg && ({1'b0, rank_reg} < old_rank))
            begin
                rank_reg <= rank_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write && sel)
        begin
            addr_reg   <= cmd.address;
            score_reg  <= cmd.score;
            wstart_reg <= cmd.wstart;
            expiry_reg <= cmd.expiry;
        end
    end

endmodule

FILE: design/ipsb_select.sv
// Registered one-hot pick over the cell row: hit cell, lowest free cell, LRU tail.
// Depends on ipsb_pkg. Produces the target cell for the update cycle.
module ipsb_select #(
    parameter int N  = 64
) (
    input  logic          clk,
    input  logic [N-1:0]  hit,
    input  logic [N-1:0]  valid,
    input  logic [N-1:0]  free_chain,
    input  logic [N-1:0]  tail,
    output logic [N-1:0]  hit_oh_reg,
    output logic [N-1:0]  free_oh_reg,
    output logic [N-1:0]  tail_oh_reg,
    output logic          any_hit_reg,
    output logic          any_free_reg
);
    import ipsb_pkg::*;

    logic [N-1:0] free_oh_next;

    // A cell is the first free one when it is free and no lower cell is.
    assign free_oh_next = ~valid & ~{free_chain[N-2:0], 1'b0};

    always_ff @(posedge clk)
    begin
        hit_oh_reg   <= hit;
        free_oh_reg  <= free_oh_next;
        tail_oh_reg  <= tail;
        any_hit_reg  <= |hit;
        any_free_reg <= free_chain[N-1];
    end

endmodule

FILE: design/ip_score_block_table_core.sv
// Address score and block table with LRU replacement, built as a row of cells.
// The cells match the incoming address at acceptance, and the update cycle
// writes the chosen cell and loads the result register. Each request passes
// through accept, update and result handoff, which waits for out_ready; the
// controller takes one at a time because each LRU update feeds the next lookup.
// Reset clears every valid bit and rank at once and loads register defaults.
module ip_score_block_table_core #(
    parameter int NUM_ENTRIES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        func,
    input  logic [31:0] ip_address,
    input  logic [15:0] delta,
    input  logic [31:0] now_ms,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        banned,
    output logic [2:0]  status,
    output logic [31:0] updated_score,
    output logic        newly_blocked
);
    import ipsb_pkg::*;

    localparam int RW = $clog2(NUM_ENTRIES);
    localparam int N  = NUM_ENTRIES;
    localparam logic [1:0] CFG_THRESH = 2'd0;
    localparam logic [1:0] CFG_WINDOW = 2'd1;
    localparam logic [1:0] CFG_DUR    = 2'd2;

    // Configuration registers.
    logic [31:0] thresh_reg, window_reg, dur_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= 32'd0;
            window_reg <= 32'd60000;
            dur_reg    <= 32'd600000;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_THRESH: thresh_reg <= cfg_wdata;
                CFG_WINDOW: window_reg <= cfg_wdata;
                CFG_DUR:    dur_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // The request is captured for the update cycle. The cells compare against
    // the incoming address, so the pick is registered at the accepting edge.
    state_t      state_reg, state_next;
    logic        func_reg;
    logic [31:0] addr_reg, now_reg;
    logic [15:0] delta_reg;

    // Result register.
    logic        banned_reg, banned_next;
    status_t     status_reg, status_next;
    logic [31:0] score_reg, score_next;
    logic        newly_reg, newly_next;

    // Cell row.
    cell_cmd_t     cmd;
    logic [N-1:0]  sel;
    logic [RW:0]   old_rank;
    logic [N-1:0]  hit, valid, free_chain, tail;
    logic [RW-1:0] rank [N];
    logic [31:0]   c_score [N];
    logic [31:0]   c_wstart [N];
    logic [31:0]   c_expiry [N];

    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_cell
            logic fin;
            if (g == 0) begin : g_first
                assign fin = 1'b0;
            end
            else begin : g_rest
                assign fin = free_chain[g-1];
            end
            ipsb_cell #(.RW(RW)) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .match_addr(ip_address),
                .sel       (sel[g]),
                .old_rank  (old_rank),
                .cmd       (cmd),
                .free_in   (fin),
                .free_out  (free_chain[g]),
                .hit       (hit[g]),
                .valid     (valid[g]),
                .rank      (rank[g]),
                .score     (c_score[g]),
                .wstart    (c_wstart[g]),
                .expiry    (c_expiry[g])
            );
            assign tail[g] = valid[g] && (rank[g] == RW'(N - 1));
        end
    endgenerate

    logic [N-1:0] hit_oh, free_oh, tail_oh;
    logic         any_hit, any_free;

    ipsb_select #(.N(N)) u_sel (
        .clk         (clk),
        .hit         (hit),
        .valid       (valid),
        .free_chain  (free_chain),
        .tail        (tail),
        .hit_oh_reg  (hit_oh),
        .free_oh_reg (free_oh),
        .tail_oh_reg (tail_oh),
        .any_hit_reg (any_hit),
        .any_free_reg(any_free)
    );

    // Read back the chosen cell with one-hot OR muxes.
    logic [N-1:0]  tgt;
    logic [RW-1:0] t_rank;
    logic [31:0]   t_score, t_wstart, t_expiry;

    always_comb
    begin
        t_rank   = '0;
        t_score  = '0;
        t_wstart = '0;
        t_expiry = '0;
        for (int i = 0; i < N; i++)
        begin
            if (tgt[i])
            begin
                t_rank   = t_rank | rank[i];
                t_score  = t_score | c_score[i];
                t_wstart = t_wstart | c_wstart[i];
                t_expiry = t_expiry | c_expiry[i];
            end
        end
    end

    // Update datapath.
    logic        is_ignored, evict_blocked;
    logic [31:0] base_score, base_wstart, base_exp;
    logic [32:0] sum;
    logic [31:0] sat;
    logic        start_block;

    always_comb
    begin
        state_next  = state_reg;
        banned_next = banned_reg;
        status_next = status_reg;
        score_next  = score_reg;
        newly_next  = newly_reg;
        cmd         = '0;
        sel         = '0;
        old_rank    = (RW + 1)'(N);
        tgt         = any_hit ? hit_oh : (any_free ? free_oh : tail_oh);
        is_ignored  = (addr_reg == 32'd0) || (func_reg == FUNC_ADD && thresh_reg == 32'd0);
        evict_blocked = !any_hit && !any_free && (t_expiry > now_reg);
        base_score  = t_score;
        base_wstart = t_wstart;
        base_exp    = t_expiry;
        if (!any_hit)
        begin
            base_score  = 32'd0;
            base_wstart = now_reg;
            base_exp    = 32'd0;
        end
        else if (window_reg != 32'd0 && (now_reg - t_wstart) >= window_reg)
        begin
            base_score  = 32'd0;
            base_wstart = now_reg;
        end
        sum         = {1'b0, base_score} + {17'd0, delta_reg};
        sat         = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        start_block = (sat > thresh_reg) && (base_exp == 32'd0 || base_exp <= now_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_LOOK;
            end
            S_LOOK:
            begin
                banned_next = 1'b0;
                score_next  = 32'd0;
                newly_next  = 1'b0;
                state_next  = S_OUT;
                if (is_ignored)
                begin
                    status_next = ST_IGNORED;
                end
                else if (func_reg == FUNC_CHECK)
                begin
                    if (!any_hit)
                    begin
                        status_next = ST_NOT_FOUND;
                    end
                    else
                    begin
                        status_next = ST_HIT;
                        sel         = hit_oh;
                        old_rank    = {1'b0, t_rank};
                        cmd.promote = 1'b1;
                        cmd.write   = 1'b1;
                        cmd.address = addr_reg;
                        cmd.score   = t_score;
                        cmd.wstart  = t_wstart;
                        cmd.expiry  = t_expiry;
                        if (t_expiry != 32'd0)
                        begin
                            if (t_expiry > now_reg)
                                banned_next = 1'b1;
                            else
                                cmd.expiry = 32'd0;
                        end
                    end
                end
                else if (evict_blocked)
                begin
                    status_next = ST_DROPPED;
                end
                else
                begin
                    status_next = any_hit ? ST_HIT : ST_NEW;
                    sel         = tgt;
                    if (any_hit || !any_free)
                        old_rank = {1'b0, t_rank};
                    cmd.promote = 1'b1;
                    cmd.write   = 1'b1;
                    cmd.address = addr_reg;
                    cmd.score   = sat;
                    cmd.wstart  = base_wstart;
                    cmd.expiry  = start_block ? (now_reg + dur_reg) : base_exp;
                    score_next  = sat;
                    newly_next  = start_block;
                end
            end
            S_OUT:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            func_reg  <= func;
            addr_reg  <= ip_address;
            delta_reg <= delta;
            now_reg   <= now_ms;
        end
        banned_reg <= banned_next;
        status_reg <= status_next;
        score_reg  <= score_next;
        newly_reg  <= newly_next;
    end

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = (state_reg == S_OUT);
    assign banned        = banned_reg;
    assign status        = status_reg;
    assign updated_score = score_reg;
    assign newly_blocked = newly_reg;

endmodule
